[src/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, widths, status codes and helpers of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int CNT_W    = 16;
	localparam int ADDR_W   = 64;
	localparam int USABLE_W = 13;
	localparam int ORD_W    = 5;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_MEM   = 2'd1,
		ST_BAD      = 2'd2,
		ST_IGNORED  = 2'd3
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0] block_address;
		status_t           status;
	} res_t;

	// Order of the smallest power of two that covers c (c >= 1).
	function automatic logic [ORD_W-1:0] round_order(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] m;
		logic [ORD_W-1:0] o;
		m = c - CNT_W'(1);
		o = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (m[i]) o = ORD_W'(i + 1);
		end
		return o;
	endfunction

endpackage

[src/bpa_engine.sv]
// ----------------------------------------------------------------------------
// bpa_engine
// Sequencer for allocate and free: frame metadata and next links live in two
// synchronous-read memories, list heads and lengths in registers.
// ----------------------------------------------------------------------------
module bpa_engine #(
	parameter int PAGES      = 4096,
	parameter int NUM_ORDERS = 13,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bpa_pkg::USABLE_W-1:0]  usable_pages,
	input  logic [bpa_pkg::ADDR_W-1:0]    direct_map_offset,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [bpa_pkg::CNT_W-1:0]     page_count,
	input  logic [bpa_pkg::ADDR_W-1:0]    address,
	input  logic                          use_offset,
	output logic                          res_valid,
	input  logic                          res_ready,
	output bpa_pkg::res_t                 res
);
	import bpa_pkg::*;

	localparam int FW     = $clog2(PAGES);
	localparam int LW     = $clog2(NUM_ORDERS);
	localparam int LIM_W  = (FW + 1 > USABLE_W) ? FW + 1 : USABLE_W;
	localparam int SW     = (FW + 1 > 21) ? FW + 1 : 21;
	localparam int META_W = ORD_W + 1;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_SEARCH, S_NEXT, S_WAIT,
		S_SPLIT_POP, S_BUD_CHK, S_BUD_PUSH, S_FINAL_POP,
		S_F_MARK, S_M_STEP, S_M_CHK, S_M_NEXT, S_F_PUSH,
		S_U_START, S_U_HEAD, S_U_WALK, S_U_FIX, S_DONE
	} state_t;

	state_t state_q, after_q, ret_q;

	logic [FW-1:0]     addr_q, idx_q, bud_q, prev_q, ui_q, clr_q;
	logic [FW:0]       k_q;
	logic [ORD_W-1:0]  ord_q, cur_q, uo_q, uord_q;
	logic              mode_q, cnt_zero_q, addr_zero_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] ext_q, off_q;
	logic [FW-1:0]     head_q [NUM_ORDERS];
	logic [FW:0]       len_q  [NUM_ORDERS];
	res_t              res_q;

	// memories
	logic [META_W-1:0] meta_mem [PAGES];
	logic [FW-1:0]     link_mem [PAGES];
	logic [META_W-1:0] meta_rd;
	logic [FW-1:0]     link_rd;
	logic              meta_we, link_we;
	logic [FW-1:0]     meta_wa, link_wa, link_wd;
	logic [META_W-1:0] meta_wd;

	always_ff @(posedge clk) begin
		if (meta_we) meta_mem[meta_wa] <= meta_wd;
		if (link_we) link_mem[link_wa] <= link_wd;
		meta_rd <= meta_mem[addr_q];
		link_rd <= link_mem[addr_q];
	end

	logic              rd_mark;
	logic [ORD_W-1:0]  rd_ord;
	assign rd_mark = meta_rd[ORD_W];
	assign rd_ord  = meta_rd[ORD_W-1:0];

	logic [LW-1:0]     ord_i, cur_i, c1_i, uo_i;
	logic [ORD_W-1:0]  c1;
	assign c1    = cur_q - ORD_W'(1);
	assign ord_i = ord_q[LW-1:0];
	assign cur_i = cur_q[LW-1:0];
	assign c1_i  = c1[LW-1:0];
	assign uo_i  = uo_q[LW-1:0];

	logic [LIM_W-1:0]  limit, use_ext, pages_c;
	assign use_ext = LIM_W'(usable_pages);
	assign pages_c = LIM_W'(PAGES);
	assign limit   = (use_ext < pages_c) ? use_ext : pages_c;

	logic              frame_over;
	logic [FW-1:0]     pfn;
	logic [ORD_W-1:0]  ord_c;
	assign frame_over = (|ext_q[ADDR_W-1:PAGE_SHIFT+LIM_W])
		|| (ext_q[PAGE_SHIFT+LIM_W-1:PAGE_SHIFT] >= limit);
	assign pfn   = ext_q[PAGE_SHIFT+FW-1:PAGE_SHIFT];
	assign ord_c = round_order(cnt_q);

	logic [SW-1:0]     split_bud, merge_bud;
	assign split_bud = SW'(addr_q) + (SW'(1) << c1);
	assign merge_bud = SW'(idx_q) ^ (SW'(1) << ord_q);

	logic              uo_ok;
	logic [FW:0]       un;
	assign uo_ok = uo_q < ORD_W'(NUM_ORDERS);
	assign un    = uo_ok ? len_q[uo_i] : '0;

	// memory writes, decided by state alone
	always_comb begin
		meta_we = 1'b0;
		meta_wa = addr_q;
		meta_wd = '0;
		link_we = 1'b0;
		link_wa = addr_q;
		link_wd = '0;
		unique case (state_q)
			S_CLEAR: begin
				meta_we = 1'b1;
				meta_wa = clr_q;
			end
			S_SPLIT_POP: begin
				meta_we = 1'b1;
				meta_wd = {1'b1, c1};
				link_we = 1'b1;
				link_wd = (len_q[c1_i] != '0) ? head_q[c1_i] : '0;
			end
			S_BUD_PUSH: begin
				meta_we = 1'b1;
				meta_wa = bud_q;
				meta_wd = {1'b1, cur_q};
				link_we = 1'b1;
				link_wa = bud_q;
				link_wd = (len_q[cur_i] != '0) ? head_q[cur_i] : '0;
			end
			S_FINAL_POP: begin
				meta_we = 1'b1;
				meta_wd = {1'b0, rd_ord};
			end
			S_F_PUSH: begin
				meta_we = 1'b1;
				meta_wa = idx_q;
				meta_wd = {1'b1, ord_q};
				link_we = 1'b1;
				link_wa = idx_q;
				link_wd = (len_q[ord_i] != '0) ? head_q[ord_i] : '0;
			end
			S_U_START: begin
				meta_we = 1'b1;
				meta_wa = ui_q;
				meta_wd = {1'b0, uord_q};
			end
			S_U_FIX: begin
				link_we = 1'b1;
				link_wa = prev_q;
				link_wd = link_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			after_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			clr_q       <= '0;
			addr_q      <= '0;
			idx_q       <= '0;
			bud_q       <= '0;
			prev_q      <= '0;
			ui_q        <= '0;
			k_q         <= '0;
			ord_q       <= '0;
			cur_q       <= '0;
			uo_q        <= '0;
			uord_q      <= '0;
			mode_q      <= 1'b0;
			cnt_zero_q  <= 1'b0;
			addr_zero_q <= 1'b0;
			cnt_q       <= '0;
			ext_q       <= '0;
			off_q       <= '0;
			res_q       <= '0;
			for (int i = 0; i < NUM_ORDERS; i++) begin
				head_q[i] <= '0;
				len_q[i]  <= '0;
			end
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + FW'(1);
					if (clr_q == FW'(PAGES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						mode_q      <= mode;
						cnt_q       <= page_count;
						cnt_zero_q  <= page_count == '0;
						addr_zero_q <= address == '0;
						off_q       <= use_offset ? direct_map_offset : '0;
						ext_q       <= address - (use_offset ? direct_map_offset : '0);
						state_q     <= S_DECODE;
					end
				end
				S_DECODE: begin
					ord_q               <= ord_c;
					cur_q               <= ord_c;
					res_q.block_address <= '0;
					idx_q               <= pfn;
					if (!mode_q) begin
						if (cnt_zero_q || ord_c >= ORD_W'(NUM_ORDERS)) begin
							res_q.status <= ST_BAD;
							state_q      <= S_DONE;
						end else begin
							res_q.status <= ST_OK;
							state_q      <= S_SEARCH;
						end
					end else begin
						priority if (cnt_zero_q || addr_zero_q || frame_over) begin
							res_q.status <= ST_IGNORED;
							state_q      <= S_DONE;
						end else if (ord_c >= ORD_W'(NUM_ORDERS)) begin
							res_q.status <= ST_BAD;
							state_q      <= S_DONE;
						end else begin
							res_q.status <= ST_OK;
							addr_q       <= pfn;
							after_q      <= S_F_MARK;
							state_q      <= S_WAIT;
						end
					end
				end
				S_SEARCH: begin
					priority if (cur_q >= ORD_W'(NUM_ORDERS)) begin
						res_q.status <= ST_NO_MEM;
						state_q      <= S_DONE;
					end else if (len_q[cur_i] == '0) begin
						cur_q <= cur_q + ORD_W'(1);
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					// split further down, or pop the block of the wanted order
					addr_q  <= head_q[cur_i];
					after_q <= (cur_q > ord_q) ? S_SPLIT_POP : S_FINAL_POP;
					state_q <= S_WAIT;
				end
				S_WAIT: state_q <= after_q;
				S_SPLIT_POP: begin
					head_q[cur_i] <= link_rd;
					len_q[cur_i]  <= len_q[cur_i] - (FW+1)'(1);
					head_q[c1_i]  <= addr_q;
					len_q[c1_i]   <= len_q[c1_i] + (FW+1)'(1);
					cur_q         <= c1;
					if (split_bud < SW'(PAGES)) begin
						bud_q   <= split_bud[FW-1:0];
						addr_q  <= split_bud[FW-1:0];
						after_q <= S_BUD_CHK;
						state_q <= S_WAIT;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_BUD_CHK: begin
					if (rd_mark) begin
						uo_q    <= rd_ord;
						uord_q  <= rd_ord;
						ui_q    <= bud_q;
						ret_q   <= S_BUD_PUSH;
						state_q <= S_U_START;
					end else begin
						state_q <= S_BUD_PUSH;
					end
				end
				S_BUD_PUSH: begin
					head_q[cur_i] <= bud_q;
					len_q[cur_i]  <= len_q[cur_i] + (FW+1)'(1);
					state_q       <= S_NEXT;
				end
				S_FINAL_POP: begin
					head_q[ord_i]       <= link_rd;
					len_q[ord_i]        <= len_q[ord_i] - (FW+1)'(1);
					res_q.block_address <= (ADDR_W'(addr_q) << PAGE_SHIFT) + off_q;
					state_q             <= S_DONE;
				end
				S_F_MARK: begin
					if (rd_mark) begin
						res_q.status <= ST_IGNORED;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_M_STEP;
					end
				end
				S_M_STEP: begin
					if (ord_q >= ORD_W'(NUM_ORDERS - 1) || merge_bud >= SW'(limit)) begin
						state_q <= S_F_PUSH;
					end else begin
						bud_q   <= merge_bud[FW-1:0];
						addr_q  <= merge_bud[FW-1:0];
						after_q <= S_M_CHK;
						state_q <= S_WAIT;
					end
				end
				S_M_CHK: begin
					if (!rd_mark || rd_ord != ord_q) begin
						state_q <= S_F_PUSH;
					end else begin
						uo_q    <= ord_q;
						uord_q  <= rd_ord;
						ui_q    <= bud_q;
						ret_q   <= S_M_NEXT;
						state_q <= S_U_START;
					end
				end
				S_M_NEXT: begin
					if (bud_q < idx_q) idx_q <= bud_q;
					ord_q   <= ord_q + ORD_W'(1);
					state_q <= S_M_STEP;
				end
				S_F_PUSH: begin
					head_q[ord_i] <= idx_q;
					len_q[ord_i]  <= len_q[ord_i] + (FW+1)'(1);
					state_q       <= S_DONE;
				end
				S_U_START: begin
					priority if (un == '0) begin
						state_q <= ret_q;
					end else if (head_q[uo_i] == ui_q) begin
						addr_q  <= ui_q;
						after_q <= S_U_HEAD;
						state_q <= S_WAIT;
					end else if (un == (FW+1)'(1)) begin
						state_q <= ret_q;
					end else begin
						prev_q  <= head_q[uo_i];
						k_q     <= (FW+1)'(1);
						addr_q  <= head_q[uo_i];
						after_q <= S_U_WALK;
						state_q <= S_WAIT;
					end
				end
				S_U_HEAD: begin
					head_q[uo_i] <= link_rd;
					len_q[uo_i]  <= len_q[uo_i] - (FW+1)'(1);
					state_q      <= ret_q;
				end
				S_U_WALK: begin
					priority if (link_rd == ui_q) begin
						addr_q  <= ui_q;
						after_q <= S_U_FIX;
						state_q <= S_WAIT;
					end else if (k_q + (FW+1)'(1) >= un) begin
						state_q <= ret_q;
					end else begin
						prev_q  <= link_rd;
						k_q     <= k_q + (FW+1)'(1);
						addr_q  <= link_rd;
						after_q <= S_U_WALK;
						state_q <= S_WAIT;
					end
				end
				S_U_FIX: begin
					len_q[uo_i] <= len_q[uo_i] - (FW+1)'(1);
					state_q     <= ret_q;
				end
				S_DONE: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res       = res_q;

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_OK |-> res.block_address == '0)
		else $error("failed request carries an address");

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DECODE)
		else $error("accepted item not decoded");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while waiting");

endmodule

[src/buddy_page_allocator_top.sv]
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// Buddy page allocator with stream request and response channels.
// ----------------------------------------------------------------------------
// After reset the block sweeps its frame metadata memory, one frame a cycle,
// before it takes the first request; configuration writes are taken
// throughout. One request is in work at a time. Each memory access goes
// through the address register and then the registered read data; an
// allocate searches upward past empty orders and splits blocks, plus list
// walks when a split half must first be unlinked, while a free merges
// buddies and walks list entries when unlinking a buddy. Walks of long
// lists set the worst case.
// A finished response waits in an output register so the next request can be
// accepted meanwhile.
module buddy_page_allocator_top #(
	parameter int PAGES      = 4096,
	parameter int NUM_ORDERS = 13,
	parameter int PAGE_SHIFT = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // page_count[15:0], address[79:16]
	input  logic [1:0]  s_tuser,   // mode[0], use_offset[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // block_address[63:0], status[65:64], zero pad
);
	import bpa_pkg::*;

	localparam logic CFG_USABLE = 1'b0;
	localparam logic CFG_OFFSET = 1'b1;

	logic [USABLE_W-1:0] usable_q;
	logic [ADDR_W-1:0]   offset_q;
	logic                eng_valid, eng_ready;
	res_t                eng_res, out_q;
	logic                out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q <= '0;
			offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_USABLE: usable_q <= cfg_data[USABLE_W-1:0];
				CFG_OFFSET: offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bpa_engine #(
		.PAGES      (PAGES),
		.NUM_ORDERS (NUM_ORDERS),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_engine (
		.clk               (clk),
		.arst_n            (arst_n),
		.usable_pages      (usable_q),
		.direct_map_offset (offset_q),
		.in_valid          (s_tvalid),
		.in_ready          (s_tready),
		.mode              (s_tuser[0]),
		.page_count        (s_tdata[15:0]),
		.address           (s_tdata[79:16]),
		.use_offset        (s_tuser[1]),
		.res_valid         (eng_valid),
		.res_ready         (eng_ready),
		.res               (eng_res)
	);

	// load the output register when it is empty or being drained
	assign eng_ready = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else if (eng_ready) begin
			out_v_q <= eng_valid;
			if (eng_valid) out_q <= eng_res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'b0, out_q.status, out_q.block_address};

endmodule
